/* rtl/stbeq_pkg.sv */
// -----------------------------------------------------------------------------
// stbeq_pkg
// Shared types, constants and fixed-point helpers for the stereo three-band
// biquad equaliser.
// -----------------------------------------------------------------------------
package stbeq_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 20;
  localparam int COEF_FRAC   = 17;
  localparam int DELAY_BITS  = 32;
  localparam int DELAY_ALIGN = SAMPLE_BITS - 15;
  localparam int FF_BITS     = 3 * COEF_BITS;
  localparam int FB_BITS     = 2 * COEF_BITS;
  localparam int CFG_DATA_W  = FF_BITS;
  localparam int PROD_W      = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + 3;

  localparam logic [FF_BITS-1:0] FF_RESET = FF_BITS'(1) << COEF_FRAC;
  localparam logic [FB_BITS-1:0] FB_RESET = '0;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          clear_history;
  } stbeq_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } stbeq_out_t;

  // One state per multiplier slot of a section, plus the final subtract, the delay write-back, idle and hand-over.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MB0,
    ST_Y,
    ST_MA1,
    ST_MB2,
    ST_MA2,
    ST_SUB2,
    ST_W2,
    ST_DONE
  } stbeq_step_t;

  typedef struct packed {
    stbeq_step_t step;
    logic        load;
    logic        clr;
    logic        handover;
  } stbeq_ctrl_t;

  // Round half up by COEF_FRAC bits, then saturate to the sample format.
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat_sample(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    t  = (v + (ACC_W'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    hi = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    lo = ~hi;
    if (t > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (t < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return t[SAMPLE_BITS-1:0];
  endfunction

  // Round half up by DELAY_ALIGN bits, then saturate to the delay format.
  function automatic logic signed [DELAY_BITS-1:0] round_sat_delay(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    t  = (v + (ACC_W'(1) <<< (DELAY_ALIGN - 1))) >>> DELAY_ALIGN;
    hi = (ACC_W'(1) <<< (DELAY_BITS - 1)) - ACC_W'(1);
    lo = ~hi;
    if (t > hi) begin
      return hi[DELAY_BITS-1:0];
    end else if (t < lo) begin
      return lo[DELAY_BITS-1:0];
    end
    return t[DELAY_BITS-1:0];
  endfunction

endpackage

/* rtl/stbeq_ctrl.sv */
// -----------------------------------------------------------------------------
// stbeq_ctrl
// Section sequencer shared by both channel lanes: steps through the five
// multiplier slots and the delay write-back of each band in turn.
// -----------------------------------------------------------------------------
module stbeq_ctrl
  import stbeq_pkg::*;
#(
  parameter int BAND_COUNT = 3,
  parameter int BAND_W     = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              clear_history,
  input  logic              merge_ready,
  output logic              in_stall,
  output stbeq_ctrl_t       ctrl,
  output logic [BAND_W-1:0] band
);

  stbeq_step_t       state_r, state_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  logic              clr_r, clr_nxt;
  logic              last_band;

  assign last_band = (band_r == BAND_W'(BAND_COUNT - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MB0;
        end
      end
      ST_MB0:  state_nxt = ST_Y;
      ST_Y:    state_nxt = ST_MA1;
      ST_MA1:  state_nxt = ST_MB2;
      ST_MB2:  state_nxt = ST_MA2;
      ST_MA2:  state_nxt = ST_SUB2;
      ST_SUB2: state_nxt = ST_W2;
      ST_W2: begin
        state_nxt = last_band ? ST_DONE : ST_MB0;
      end
      ST_DONE: begin
        if (merge_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    band_nxt = band_r;
    clr_nxt  = clr_r;
    if (state_r == ST_IDLE && in_valid) begin
      band_nxt = '0;
      clr_nxt  = clear_history;
    end else if (state_r == ST_W2 && !last_band) begin
      band_nxt = band_r + BAND_W'(1);
    end
  end

  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    ctrl.step     = state_r;
    ctrl.load     = (state_r == ST_IDLE) && in_valid;
    ctrl.clr      = clr_r;
    ctrl.handover = (state_r == ST_DONE) && merge_ready;
    band          = band_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      band_r  <= '0;
      clr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      band_r  <= band_nxt;
      clr_r   <= clr_nxt;
    end
  end

endmodule

/* rtl/stbeq_lane.sv */
// -----------------------------------------------------------------------------
// stbeq_lane
// One channel's datapath: a single multiplier and accumulator shared over
// all sections of the cascade, with that channel's z1/z2 delay registers.
// -----------------------------------------------------------------------------
module stbeq_lane
  import stbeq_pkg::*;
#(
  parameter int BAND_COUNT = 3,
  parameter int BAND_W     = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stbeq_ctrl_t                   ctrl,
  input  logic [BAND_W-1:0]             band,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [COEF_BITS-1:0]   coef,
  output logic signed [SAMPLE_BITS-1:0] y_out
);

  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic signed [SAMPLE_BITS-1:0] y_r, y_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [DELAY_BITS-1:0]  z1_r [BAND_COUNT];
  logic signed [DELAY_BITS-1:0]  z2_r [BAND_COUNT];

  logic signed [SAMPLE_BITS-1:0] opnd;
  logic signed [PROD_W-1:0]      mul_res;
  logic signed [ACC_W-1:0]       prod_ext;
  logic signed [DELAY_BITS-1:0]  z1_cur, z2_cur;
  logic signed [ACC_W-1:0]       z1_ext, z2_ext;
  logic signed [DELAY_BITS-1:0]  z_wdata;

  // Feedback slots multiply the section output, the rest the section input.
  assign opnd     = (ctrl.step == ST_MA1 || ctrl.step == ST_MA2) ? y_r : x_r;
  assign mul_res  = coef * opnd;
  assign prod_ext = ACC_W'(prod_r);

  // A clearing transfer reads every band's history as zero until rewritten.
  assign z1_cur   = ctrl.clr ? '0 : z1_r[band];
  assign z2_cur   = ctrl.clr ? '0 : z2_r[band];
  assign z1_ext   = ACC_W'(z1_cur) <<< DELAY_ALIGN;
  assign z2_ext   = ACC_W'(z2_cur) <<< DELAY_ALIGN;
  assign z_wdata  = round_sat_delay(acc_r);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (ctrl.load) begin
      x_nxt = sample;
    end
    case (ctrl.step)
      ST_MB0: begin
        prod_nxt = mul_res;
      end
      ST_Y: begin
        y_nxt    = round_sat_sample(prod_ext + z1_ext);
        prod_nxt = mul_res;
      end
      ST_MA1: begin
        acc_nxt  = prod_ext + z2_ext;
        prod_nxt = mul_res;
      end
      ST_MB2: begin
        acc_nxt  = acc_r - prod_ext;
        prod_nxt = mul_res;
      end
      ST_MA2: begin
        acc_nxt  = prod_ext;
        prod_nxt = mul_res;
      end
      ST_SUB2: begin
        acc_nxt = acc_r - prod_ext;
      end
      ST_W2: begin
        // Pass the section output on to the next band.
        x_nxt = y_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BAND_COUNT; b++) begin
        z1_r[b] <= '0;
        z2_r[b] <= '0;
      end
    end else begin
      if (ctrl.step == ST_MA2) begin
        z1_r[band] <= z_wdata;
      end
      if (ctrl.step == ST_W2) begin
        z2_r[band] <= z_wdata;
      end
    end
  end

  assign y_out = y_r;

endmodule

/* rtl/stbeq_merge.sv */
// -----------------------------------------------------------------------------
// stbeq_merge
// Joins the two lane results into one stereo result and holds it in the
// output register until the downstream side takes the transfer.
// -----------------------------------------------------------------------------
module stbeq_merge
  import stbeq_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  stbeq_ctrl_t                   ctrl,
  input  logic signed [SAMPLE_BITS-1:0] left_y,
  input  logic signed [SAMPLE_BITS-1:0] right_y,
  input  logic                          out_stall,
  output logic                          out_valid,
  output stbeq_out_t                    out_payload,
  output logic                          ready
);

  logic       valid_r, valid_nxt;
  stbeq_out_t data_r, data_nxt;

  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
    if (ctrl.handover) begin
      valid_nxt          = 1'b1;
      data_nxt.left_out  = left_y;
      data_nxt.right_out = right_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid   = valid_r;
  assign out_payload = data_r;

endmodule

/* rtl/stereo_three_band_biquad_eq.sv */
// -----------------------------------------------------------------------------
// stereo_three_band_biquad_eq
// Stereo equaliser: a cascade of second-order sections per channel in
// transposed direct form II, coefficients from configuration registers.
// -----------------------------------------------------------------------------
// Each accepted stereo pair runs through BAND_COUNT sections on two lanes,
// left and right in parallel. A lane owns one 20x24 multiplier, so a section
// steps through its multiplier slots one after another; a pair occupies the
// block from its accepting edge until its result is handed to the output
// register, and the hand-over waits while that register is full. The result
// sits in an output register, so the next pair is taken while it waits.
// clear_history zeros every delay value before that pair is filtered. Write
// coefficients only while the block is idle; register 2*b is band b's
// b0/b1/b2, 2*b+1 its a1/a2, and writes to higher indices are dropped.
module stereo_three_band_biquad_eq
  import stbeq_pkg::*;
#(
  parameter int BAND_COUNT = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stbeq_in_t            in_payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stbeq_out_t           out_payload,
  input  logic                 cfg_we,
  input  logic [((BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1):0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BAND_W    = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int CFG_IDX_W = BAND_W + 1;

  logic [FF_BITS-1:0] ff_r [BAND_COUNT];
  logic [FB_BITS-1:0] fb_r [BAND_COUNT];

  stbeq_ctrl_t                   ctrl;
  logic [BAND_W-1:0]             band;
  logic [BAND_W-1:0]             cfg_band;
  logic                          merge_ready;
  logic [FF_BITS-1:0]            ff_cur;
  logic [FB_BITS-1:0]            fb_cur;
  logic signed [COEF_BITS-1:0]   coef;
  logic signed [SAMPLE_BITS-1:0] left_y, right_y;

  assign cfg_band = cfg_index[CFG_IDX_W-1:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BAND_COUNT; b++) begin
        ff_r[b] <= FF_RESET;
        fb_r[b] <= FB_RESET;
      end
    end else if (cfg_we && (cfg_band < BAND_W'(BAND_COUNT - 1) ||
                            cfg_band == BAND_W'(BAND_COUNT - 1))) begin
      if (cfg_index[0]) begin
        fb_r[cfg_band] <= cfg_data[FB_BITS-1:0];
      end else begin
        ff_r[cfg_band] <= cfg_data;
      end
    end
  end

  // Coefficient for the current multiplier slot, shared by both lanes.
  assign ff_cur = ff_r[band];
  assign fb_cur = fb_r[band];

  always_comb begin
    case (ctrl.step)
      ST_MB0:  coef = $signed(ff_cur[COEF_BITS-1:0]);
      ST_Y:    coef = $signed(ff_cur[2*COEF_BITS-1:COEF_BITS]);
      ST_MA1:  coef = $signed(fb_cur[COEF_BITS-1:0]);
      ST_MB2:  coef = $signed(ff_cur[3*COEF_BITS-1:2*COEF_BITS]);
      ST_MA2:  coef = $signed(fb_cur[2*COEF_BITS-1:COEF_BITS]);
      default: coef = '0;
    endcase
  end

  stbeq_ctrl #(
    .BAND_COUNT (BAND_COUNT),
    .BAND_W     (BAND_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .clear_history (in_payload.clear_history),
    .merge_ready   (merge_ready),
    .in_stall      (in_stall),
    .ctrl          (ctrl),
    .band          (band)
  );

  stbeq_lane #(
    .BAND_COUNT (BAND_COUNT),
    .BAND_W     (BAND_W)
  ) u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .band   (band),
    .sample (in_payload.left_in),
    .coef   (coef),
    .y_out  (left_y)
  );

  stbeq_lane #(
    .BAND_COUNT (BAND_COUNT),
    .BAND_W     (BAND_W)
  ) u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .band   (band),
    .sample (in_payload.right_in),
    .coef   (coef),
    .y_out  (right_y)
  );

  stbeq_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .left_y      (left_y),
    .right_y     (right_y),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_payload (out_payload),
    .ready       (merge_ready)
  );

endmodule

/* rtl/stbeq_checker.sv */
// -----------------------------------------------------------------------------
// stbeq_checker
// Port-level checks on the equaliser's transfer timing, bound to the top.
// -----------------------------------------------------------------------------
module stbeq_checker
  import stbeq_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input stbeq_out_t out_payload
);

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload))
    else $error("stbeq: stalled result changed or dropped");

  // One pair at a time: the input side closes after every transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("stbeq: input accepted while a pair is in flight");

  // A result only appears at the end of a busy period.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("stbeq: result without a pair being filtered");

  // The cascade runs through all its sections first; no result in the cycle after a transfer.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("stbeq: result appeared too early");

endmodule

bind stereo_three_band_biquad_eq stbeq_checker u_stbeq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_payload (out_payload)
);

/* tb/sv/tb_top.sv */
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo three-band biquad equaliser: stereo
// pairs are pushed through a valid/stall driver, each transfer is filtered by
// a bit-exact fixed-point model of the section cascade, and every result
// transfer is compared field by field in order. Coefficient sets cover
// reset, extreme and random values; both sides idle and stall at random.
// -----------------------------------------------------------------------------
module tb_top;
  import stbeq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BANDS      = 3;
  localparam int IDX_W          = $clog2(NUM_BANDS) + 1;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_SLACK    = 30;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_PAIRS    = 58;
  localparam int PRESSURE_PAIRS = 40;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] C_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0] C_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_LOW_FF,
    REG_LOW_FB,
    REG_MID_FF,
    REG_MID_FB,
    REG_HIGH_FF,
    REG_HIGH_FB,
    REG_SPARE_A,
    REG_SPARE_B
  } eq_reg_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  stbeq_in_t             in_payload = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  stbeq_out_t            out_payload;
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the coefficient registers and the per-band filter memory
  logic [FF_BITS-1:0]           ff_coefs [NUM_BANDS];
  logic [FB_BITS-1:0]           fb_coefs [NUM_BANDS];
  logic signed [DELAY_BITS-1:0] delay_z  [NUM_BANDS][2][2];

  stbeq_in_t  pending_pairs[$];
  stbeq_out_t filtered_pairs[$];

  int error_count   = 0;
  int send_gap      = 0;
  int stall_left    = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  bit sender_idling   = 1'b0;
  bit receiver_idling = 1'b0;

  always #2 clk = ~clk;

  stereo_three_band_biquad_eq #(
    .BAND_COUNT(NUM_BANDS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic longint clamp_to(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Round half up: add half an LSB, then floor
  function automatic longint round_up_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint coef_at(logic [FF_BITS-1:0] word, int slot);
    logic signed [COEF_BITS-1:0] c;
    c = word[slot*COEF_BITS +: COEF_BITS];
    return longint'(c);
  endfunction

  // One transposed direct form II section on one channel; updates its memory
  function automatic longint filter_section(int band, int ch, longint x);
    longint b0, b1, b2, a1, a2, z1, z2, y, n1, n2;
    b0 = coef_at(ff_coefs[band], 0);
    b1 = coef_at(ff_coefs[band], 1);
    b2 = coef_at(ff_coefs[band], 2);
    a1 = coef_at(FF_BITS'(fb_coefs[band]), 0);
    a2 = coef_at(FF_BITS'(fb_coefs[band]), 1);
    z1 = longint'(delay_z[band][ch][0]) * (longint'(1) << DELAY_ALIGN);
    z2 = longint'(delay_z[band][ch][1]) * (longint'(1) << DELAY_ALIGN);
    y  = clamp_to(round_up_shift(b0 * x + z1, COEF_FRAC), SAMPLE_BITS);
    n1 = b1 * x - a1 * y + z2;
    n2 = b2 * x - a2 * y;
    delay_z[band][ch][0] = DELAY_BITS'(clamp_to(round_up_shift(n1, DELAY_ALIGN), DELAY_BITS));
    delay_z[band][ch][1] = DELAY_BITS'(clamp_to(round_up_shift(n2, DELAY_ALIGN), DELAY_BITS));
    return y;
  endfunction

  function automatic stbeq_out_t equalise_pair(stbeq_in_t pair);
    longint     s [2];
    stbeq_out_t res;
    s[0] = longint'(pair.left_in);
    s[1] = longint'(pair.right_in);
    if (pair.clear_history) begin
      foreach (delay_z[b, c, k]) delay_z[b][c][k] = '0;
    end
    for (int b = 0; b < NUM_BANDS; b++) begin
      for (int c = 0; c < 2; c++) begin
        s[c] = filter_section(b, c, s[c]);
      end
    end
    res.left_out  = s[0][SAMPLE_BITS-1:0];
    res.right_out = s[1][SAMPLE_BITS-1:0];
    return res;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [COEF_BITS-1:0] rand_coef(int centre, int span);
    int v;
    v = centre + int'($urandom_range(0, 2 * span)) - span;
    return v[COEF_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return SAMPLE_BITS'($urandom());
    end else if (r < 8) begin
      return SAMPLE_BITS'(int'($urandom_range(0, 4000)) - 2000);
    end
    return $urandom_range(0, 1) ? S_MAX : S_MIN;
  endfunction

  function automatic stbeq_in_t make_pair(logic signed [SAMPLE_BITS-1:0] l,
                                          logic signed [SAMPLE_BITS-1:0] r,
                                          logic clr);
    stbeq_in_t p;
    p.left_in       = l;
    p.right_in      = r;
    p.clear_history = clr;
    return p;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Call just after a rising edge; leaves cfg_we high for the caller to drop
  task automatic write_reg(eq_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (int'(idx) < 2 * NUM_BANDS) begin
      if (idx[0]) begin
        fb_coefs[int'(idx) / 2] = data[FB_BITS-1:0];
      end else begin
        ff_coefs[int'(idx) / 2] = data;
      end
    end
    @(posedge clk);
  endtask

  task automatic load_all(logic [CFG_DATA_W-1:0] ff, logic [CFG_DATA_W-1:0] fb);
    @(posedge clk);
    for (int i = 0; i < 2 * NUM_BANDS; i++) begin
      write_reg(eq_reg_e'(i), i[0] ? fb : ff);
    end
    cfg_we <= 1'b0;
  endtask

  // Sample at the falling edge so queue and valid are settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_valid || filtered_pairs.size() != 0);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  // Driver: predict on every accepted transfer, hold a stalled payload
  always @(posedge clk) begin
    logic      nxt_valid;
    stbeq_in_t nxt_pair;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_pair  = in_payload;
      if (in_valid && !in_stall) begin
        filtered_pairs.push_back(equalise_pair(in_payload));
        nxt_valid = 1'b0;
        send_gap  = sender_idling ? draw_gap() : 0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_pairs.size() != 0) begin
          nxt_pair  = pending_pairs.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid   <= nxt_valid;
      in_payload <= nxt_pair;
    end
  end

  // Monitor: check result transfers in order, drive stall
  always @(posedge clk) begin
    stbeq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d/%0d",
                                  $signed(out_payload.left_out),
                                  $signed(out_payload.right_out)));
      end else begin
        want = filtered_pairs.pop_front();
        if (out_payload.left_out !== want.left_out) begin
          report_mismatch($sformatf("left_out %0d, want %0d",
                                    $signed(out_payload.left_out),
                                    $signed(want.left_out)));
        end
        if (out_payload.right_out !== want.right_out) begin
          report_mismatch($sformatf("right_out %0d, want %0d",
                                    $signed(out_payload.right_out),
                                    $signed(want.right_out)));
        end
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_served != hold_requests) begin
        stall_left  = HOLD_CYCLES;
        hold_served = hold_requests;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (receiver_idling && $urandom_range(0, 2) == 0) begin
          stall_left = draw_gap();
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] word;
    logic                  clr;
    for (int b = 0; b < NUM_BANDS; b++) begin
      ff_coefs[b] = FF_RESET;
      fb_coefs[b] = FB_RESET;
    end
    foreach (delay_z[b, c, k]) delay_z[b][c][k] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset coefficients pass samples straight through
    pending_pairs.push_back(make_pair('0, '0, 1'b1));
    pending_pairs.push_back(make_pair(S_MAX, S_MIN, 1'b0));
    pending_pairs.push_back(make_pair(S_MIN, S_MAX, 1'b0));
    pending_pairs.push_back(make_pair(SAMPLE_BITS'(-1), SAMPLE_BITS'(1), 1'b0));
    pending_pairs.push_back(make_pair(S_MAX, S_MAX, 1'b1));
    wait_drained();

    // Largest positive coefficients, most negative feedback: saturate everywhere
    load_all({3{C_MAX}}, {20'hABCDE, C_MIN, C_MIN});
    pending_pairs.push_back(make_pair(S_MAX, S_MIN, 1'b0));
    pending_pairs.push_back(make_pair(S_MIN, S_MAX, 1'b0));
    pending_pairs.push_back(make_pair('0, '0, 1'b0));
    pending_pairs.push_back(make_pair(S_MAX, S_MAX, 1'b0));
    pending_pairs.push_back(make_pair('0, '0, 1'b1));
    pending_pairs.push_back(make_pair(S_MIN, S_MIN, 1'b0));
    wait_drained();

    // All ones in every register; writes past the last band are dropped
    load_all('1, '1);
    @(posedge clk);
    write_reg(REG_SPARE_A, CFG_DATA_W'({$urandom(), $urandom()}));
    write_reg(REG_SPARE_B, '0);
    cfg_we <= 1'b0;
    pending_pairs.push_back(make_pair(S_MAX, S_MIN, 1'b0));
    pending_pairs.push_back(make_pair(S_MIN, SAMPLE_BITS'(-1), 1'b0));
    pending_pairs.push_back(make_pair(SAMPLE_BITS'(1), S_MAX, 1'b0));
    pending_pairs.push_back(make_pair(S_MAX, S_MAX, 1'b1));
    wait_drained();

    // Most negative feedforward, zero feedback
    load_all({3{C_MIN}}, '0);
    pending_pairs.push_back(make_pair(S_MIN, S_MAX, 1'b1));
    pending_pairs.push_back(make_pair(S_MAX, S_MIN, 1'b0));
    pending_pairs.push_back(make_pair(SAMPLE_BITS'(-1), '0, 1'b0));
    pending_pairs.push_back(make_pair(S_MIN, S_MIN, 1'b0));
    wait_drained();

    // Random coefficient sets, mostly gentle filters, some wild words
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      @(posedge clk);
      for (int i = 0; i < 2 * NUM_BANDS; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          word = CFG_DATA_W'({$urandom(), $urandom()});
        end else if (i[0]) begin
          word = {20'($urandom()), rand_coef(0, 30000), rand_coef(0, 60000)};
        end else begin
          word = {rand_coef(0, 60000), rand_coef(0, 60000), rand_coef(131072, 40000)};
        end
        write_reg(eq_reg_e'(i), word);
      end
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                CFG_DATA_W'({$urandom(), $urandom()}));
      cfg_we <= 1'b0;
      sender_idling   = (ph % 3) != 2;
      receiver_idling = (ph % 3) != 1;
      for (int n = 0; n < PHASE_PAIRS; n++) begin
        clr = ($urandom_range(0, 15) == 0);
        pending_pairs.push_back(make_pair(rand_sample(), rand_sample(), clr));
      end
      wait_drained();
    end

    // Receiver holds off while the sender keeps offering: the block fills up
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    hold_requests++;
    for (int n = 0; n < PRESSURE_PAIRS; n++) begin
      pending_pairs.push_back(make_pair(rand_sample(), rand_sample(), 1'b0));
    end
    wait_drained();

    if (filtered_pairs.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", filtered_pairs.size()));
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/stbeq_pkg.sv
rtl/stbeq_ctrl.sv
rtl/stbeq_lane.sv
rtl/stbeq_merge.sv
rtl/stereo_three_band_biquad_eq.sv
rtl/stbeq_checker.sv
tb/sv/tb_top.sv
